[src/cfr_pkg.sv]
`default_nettype none

package cfr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_CHAR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_CHAR = 1'd1;

  // configuration reset values
  localparam logic [7:0] HEADER_CHAR_RST  = 8'h41;  // 'A'
  localparam logic [7:0] TRAILER_CHAR_RST = 8'h45;  // 'E'

  // type byte values
  localparam logic [7:0] TYPE_CHAR_B = 8'h42;
  localparam logic [7:0] TYPE_CHAR_C = 8'h43;
  localparam logic [7:0] TYPE_CHAR_D = 8'h44;
  localparam logic [7:0] TYPE_CHAR_E = 8'h45;

  // frame kind codes
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_NONE     = 3'd0;
  localparam kind_t KIND_POSITION = 3'd1;
  localparam kind_t KIND_SPEED    = 3'd2;
  localparam kind_t KIND_TORQUE   = 3'd3;
  localparam kind_t KIND_SETPOINT = 3'd4;

  // payload index and count as reported (modulo 32)
  typedef logic [4:0] count_t;

  // map a type byte to its frame kind, none if not a known type
  function automatic kind_t decode_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      TYPE_CHAR_B: k = KIND_POSITION;
      TYPE_CHAR_C: k = KIND_SPEED;
      TYPE_CHAR_D: k = KIND_TORQUE;
      TYPE_CHAR_E: k = KIND_SETPOINT;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[src/command_frame_receiver.sv]
`default_nettype none

// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// input     | in_valid / in_ready   | rx_byte
// result    | out_valid / out_ready | payload_valid, payload_index, payload_byte,
//           |                       | header_seen, frame_kind, frame_complete,
//           |                       | frame_error, payload_count
// config    | cfg_we                | cfg_index, cfg_data
//
// one byte per cycle: each accepted byte is decoded against the frame position
// in the same cycle and its result lands in the output register on that edge.
// in_ready stays high while the output register is empty or being taken, so a
// stall on the result side holds back only the next byte.
// synchronous reset clears the frame status, the output valid and the two
// configuration registers to 'A' and 'E'.

module command_frame_receiver #(
  parameter int unsigned FRAME_LEN = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data,
  // received bytes
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [7:0]                      rx_byte,
  // results
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic                            payload_valid,
  output      logic [4:0]                      payload_index,
  output      logic [7:0]                      payload_byte,
  output      logic                            header_seen,
  output      logic [2:0]                      frame_kind,
  output      logic                            frame_complete,
  output      logic                            frame_error,
  output      logic [4:0]                      payload_count
);

  import cfr_pkg::*;

  localparam int unsigned POS_W = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

  // configuration registers
  logic [7:0] header_char;
  logic [7:0] trailer_char;

  // frame status
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             header_flag, header_flag_next;
  kind_t            kind_reg, kind_reg_next;
  count_t           count_reg, count_reg_next;

  // result computed for the byte at the input
  logic   res_pvalid;
  count_t res_pindex;
  logic   res_done;
  logic   res_err;
  logic   res_hs;
  kind_t  res_kind;
  count_t res_count;
  kind_t  type_kind;

  logic in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign type_kind = decode_kind(rx_byte);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_char  <= HEADER_CHAR_RST;
      trailer_char <= TRAILER_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_CHAR:  header_char  <= cfg_data;
        REG_TRAILER_CHAR: trailer_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position decode and status update
  always_comb begin
    byte_position_next = byte_position;
    header_flag_next   = header_flag;
    kind_reg_next      = kind_reg;
    count_reg_next     = count_reg;
    res_pvalid         = 1'b0;
    res_pindex         = '0;
    res_done           = 1'b0;
    res_err            = 1'b0;

    if (byte_position == POS_HEADER) begin
      header_flag_next = 1'b0;
      kind_reg_next    = KIND_NONE;
      count_reg_next   = '0;
      if (rx_byte == header_char) begin
        header_flag_next   = 1'b1;
        byte_position_next = POS_TYPE;
      end else begin
        res_err = 1'b1;
      end
    end else if (byte_position == POS_TYPE) begin
      if (type_kind != KIND_NONE) begin
        kind_reg_next      = type_kind;
        byte_position_next = byte_position + POS_W'(1);
      end else begin
        byte_position_next = POS_HEADER;
        header_flag_next   = 1'b0;
        kind_reg_next      = KIND_NONE;
        count_reg_next     = '0;
        res_err            = 1'b1;
      end
    end else if (byte_position != POS_LAST) begin
      // payload byte
      res_pvalid         = 1'b1;
      res_pindex         = count_t'(byte_position - POS_W'(2));
      count_reg_next     = count_t'(byte_position - POS_W'(1));
      byte_position_next = byte_position + POS_W'(1);
    end else begin
      if (rx_byte == trailer_char) begin
        res_done = 1'b1;
      end else begin
        header_flag_next = 1'b0;
        kind_reg_next    = KIND_NONE;
        count_reg_next   = '0;
        res_err          = 1'b1;
      end
    end

    // reported status is the one after this byte, before the clear on completion
    res_hs    = header_flag_next;
    res_kind  = kind_reg_next;
    res_count = count_reg_next;

    if (res_done || res_err) begin
      byte_position_next = POS_HEADER;
      header_flag_next   = 1'b0;
      kind_reg_next      = KIND_NONE;
      count_reg_next     = '0;
    end
  end

  // status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HEADER;
      header_flag   <= 1'b0;
      kind_reg      <= KIND_NONE;
      count_reg     <= '0;
    end else if (in_fire) begin
      byte_position <= byte_position_next;
      header_flag   <= header_flag_next;
      kind_reg      <= kind_reg_next;
      count_reg     <= count_reg_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      payload_valid  <= res_pvalid;
      payload_index  <= res_pindex;
      payload_byte   <= res_pvalid ? rx_byte : 8'd0;
      header_seen    <= res_hs;
      frame_kind     <= res_kind;
      frame_complete <= res_done;
      frame_error    <= res_err;
      payload_count  <= res_count;
    end
  end

endmodule

`default_nettype wire
